@@ rtl/window_median_3x3_top_defines.svh @@
// Assertion macros used by the median filter top module.
`ifndef WINDOW_MEDIAN_3X3_TOP_DEFINES_SVH
`define WINDOW_MEDIAN_3X3_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WM3_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent sequence ends.
`define WM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wm3_pkg.sv @@
package wm3_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChans  = 3;
  localparam int unsigned NumTaps   = 9;
  localparam int unsigned NumRows   = 3;
  localparam int unsigned PixW      = ChanW * NumChans;
  localparam int unsigned NumStages = 3;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t lo;
    chan_t mid;
    chan_t hi;
  } sort3_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic full;
  } pipe_ctl_t;

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic sort3_t sort3(chan_t a, chan_t b, chan_t c);
    sort3_t s;
    s.lo  = min3(a, b, c);
    s.mid = med3(a, b, c);
    s.hi  = max3(a, b, c);
    return s;
  endfunction

endpackage

@@ rtl/wm3_ctrl.sv @@
module wm3_ctrl
  import wm3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[2] = !valid_q[2] || out_ready_i;
    adv[1] = !valid_q[1] || adv[2];
    adv[0] = !valid_q[0] || adv[1];
  end

  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    valid_d[1] = adv[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = adv[2] ? valid_q[1] : valid_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[2];

  assign ctl_o.s1_en = adv[0];
  assign ctl_o.s2_en = adv[1];
  assign ctl_o.s3_en = adv[2];
  assign ctl_o.full  = &valid_q;

endmodule

@@ rtl/wm3_chan.sv @@
module wm3_chan
  import wm3_pkg::*;
(
  input  logic                      clk_i,
  input  pipe_ctl_t                 ctl_i,
  input  logic [NumTaps-1:0][ChanW-1:0] win_i,
  output chan_t                     med_o
);

  sort3_t row_q [NumRows];
  chan_t  max_lo_q, med_mid_q, min_hi_q;
  chan_t  med_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_en) begin
      row_q[0] <= sort3(win_i[0], win_i[1], win_i[2]);
      row_q[1] <= sort3(win_i[3], win_i[4], win_i[5]);
      row_q[2] <= sort3(win_i[6], win_i[7], win_i[8]);
    end
  end

  // The median of nine is the median of the largest low, the middle
  // middle and the smallest high of the three sorted rows.
  always_ff @(posedge clk_i) begin
    if (ctl_i.s2_en) begin
      max_lo_q  <= max3(row_q[0].lo, row_q[1].lo, row_q[2].lo);
      med_mid_q <= med3(row_q[0].mid, row_q[1].mid, row_q[2].mid);
      min_hi_q  <= min3(row_q[0].hi, row_q[1].hi, row_q[2].hi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s3_en) begin
      med_q <= med3(max_lo_q, med_mid_q, min_hi_q);
    end
  end

  assign med_o = med_q;

endmodule

@@ rtl/window_median_3x3_top.sv @@
// Channel   Signals                               Word
// in        in_valid_i / in_ready_o               nine 24-bit window pixels
// out       out_valid_o / out_ready_i             one 24-bit median pixel
// cfg       cfg_we_i / cfg_data_i                 color_mode bit, written at once
//
// One window is taken every clock while in_ready_o is high; its median leaves after
// passing the three register stages: row sort, row merge, final median.
// in_ready_o follows out_ready_i through the three stage valid bits, so a stall
// fills empty stages first and no word is lost or repeated.
// Reset clears the stage valid bits and sets color_mode to gray.
`include "window_median_3x3_top_defines.svh"

module window_median_3x3_top
  import wm3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] top_left_i,
  input  logic [PixW-1:0] top_mid_i,
  input  logic [PixW-1:0] top_right_i,
  input  logic [PixW-1:0] mid_left_i,
  input  logic [PixW-1:0] center_i,
  input  logic [PixW-1:0] mid_right_i,
  input  logic [PixW-1:0] bot_left_i,
  input  logic [PixW-1:0] bot_mid_i,
  input  logic [PixW-1:0] bot_right_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] median_pixel_o
);

  logic      color_mode_q;
  pipe_ctl_t ctl;

  logic [NumTaps-1:0][PixW-1:0] pix;
  chan_t                        med [NumChans];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      color_mode_q <= cfg_data_i;
    end
  end

  assign pix[0] = top_left_i;
  assign pix[1] = top_mid_i;
  assign pix[2] = top_right_i;
  assign pix[3] = mid_left_i;
  assign pix[4] = center_i;
  assign pix[5] = mid_right_i;
  assign pix[6] = bot_left_i;
  assign pix[7] = bot_mid_i;
  assign pix[8] = bot_right_i;

  wm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  for (genvar c = 0; c < NumChans; c++) begin : g_chan
    logic [NumTaps-1:0][ChanW-1:0] win;
    logic                          keep;

    // In gray mode the upper channels are forced to zero, so their median is zero.
    assign keep = (c == 0) || color_mode_q;

    for (genvar t = 0; t < NumTaps; t++) begin : g_tap
      assign win[t] = pix[t][c*ChanW +: ChanW] & {ChanW{keep}};
    end

    wm3_chan u_chan (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .win_i (win),
      .med_o (med[c])
    );

    assign median_pixel_o[c*ChanW +: ChanW] = med[c];
  end

  `WM3_ASSERT_SAME(a_full_stall, clk_i, rst_ni,
                   ctl.full && !out_ready_i, !in_ready_o,
                   "pipeline full and stalled but input still ready")
  `WM3_ASSERT_NEXT(a_latency, clk_i, rst_ni,
                   (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i,
                   out_valid_o,
                   "accepted word did not reach the output in three cycles")
  `WM3_ASSERT_SAME(a_no_drain_stall, clk_i, rst_ni,
                   !out_valid_o, in_ready_o,
                   "input stalled while the output stage is empty")

endmodule
